FILE: sv/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Word types, operation kinds and status codes for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int KindW   = 3;
   localparam int ValueW  = 32;
   localparam int StatusW = 2;
   localparam int CountW  = 5;

   // operation kinds
   localparam logic [KindW-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KindW-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KindW-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KindW-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KindW-1:0] KIND_CLEAR      = 3'd4;

   // result status
   localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
   localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
   localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [KindW-1:0]         kind;
      logic signed [ValueW-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [ValueW-1:0] popped_value;
      logic [StatusW-1:0]       status;
      logic [CountW-1:0]        entry_count;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                     en;
      logic [KindW-1:0]         kind;
      logic signed [ValueW-1:0] value;
   } cell_ctrl_type;

endpackage

FILE: sv/bounded_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of signed 32-bit words held in a chain of cells.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------
//  req     | in        | req_valid/req_ready| kind, push_value
//  rsp     | out       | rsp_valid/rsp_ready| popped_value, status, entry_count
//
//  One word per cycle while the response is not stalled: an accepted request
//  updates the cell chain and loads its result into the output register at the same edge.
//  The pop-back path sets the cycle time: an OR across all cells' tail words.
//  Reset clears every cell's valid flag; stored words keep
//  whatever they held.
//  A stalled response holds its word; req_ready stays high while the output
//  register is empty or being taken.
//
module bounded_deque #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bdq_pkg::rsp_type rsp_data
);
   import bdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   // chain wiring
   cell_ctrl_type            ctrl;
   logic                     cell_valid [DEPTH];
   logic signed [ValueW-1:0] cell_data  [DEPTH];
   logic signed [ValueW-1:0] cell_tail  [DEPTH];
   logic signed [ValueW-1:0] tail_word;

   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic accept, full, empty, is_push, is_pop;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign is_push = (req_data.kind == KIND_PUSH_FRONT) || (req_data.kind == KIND_PUSH_BACK);
   assign is_pop  = (req_data.kind == KIND_POP_FRONT) || (req_data.kind == KIND_POP_BACK);

   // rejected pushes and pops leave the chain alone
   always_comb begin
      ctrl.en    = accept && !(is_push && full) && !(is_pop && empty);
      ctrl.kind  = req_data.kind;
      ctrl.value = req_data.push_value;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     lv, rv;
      logic signed [ValueW-1:0] ld, rd;

      if (i == 0) begin : g_head
         // the head sees an always-valid neighbour carrying the new word
         assign lv = 1'b1;
         assign ld = req_data.push_value;
      end else begin : g_mid
         assign lv = cell_valid[i-1];
         assign ld = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign rv = 1'b0;
         assign rd = '0;
      end else begin : g_inner
         assign rv = cell_valid[i+1];
         assign rd = cell_data[i+1];
      end

      bdq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_valid (lv),
         .left_data  (ld),
         .right_valid(rv),
         .right_data (rd),
         .valid      (cell_valid[i]),
         .data       (cell_data[i]),
         .tail_data  (cell_tail[i])
      );
   end

   // at most one cell offers a non-zero tail word
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_word = tail_word | cell_tail[i];
      end
   end

   // result and next count
   always_comb begin
      count_in                 = count_ff;
      rsp_data_in.popped_value = '0;
      rsp_data_in.status       = ST_DONE;
      case (req_data.kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (full) begin
               rsp_data_in.status = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         KIND_POP_FRONT: begin
            if (empty) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               rsp_data_in.popped_value = cell_data[0];
               count_in                 = count_ff - 1'b1;
            end
         end
         KIND_POP_BACK: begin
            if (empty) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               rsp_data_in.popped_value = tail_word;
               count_in                 = count_ff - 1'b1;
            end
         end
         KIND_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      // count is reported modulo 32
      rsp_data_in.entry_count = CountW'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/bdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of the deque chain: holds a word and its valid flag, shifts
// with its neighbours on front operations, fills or drops at the tail.
// ----------------------------------------------------------------------------
module bdq_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  bdq_pkg::cell_ctrl_type        ctrl,
   input  logic                          left_valid,
   input  logic signed [31:0]            left_data,
   input  logic                          right_valid,
   input  logic signed [31:0]            right_data,
   output logic                          valid,
   output logic signed [31:0]            data,
   output logic signed [31:0]            tail_data
);
   import bdq_pkg::*;

   logic                     valid_ff, valid_in;
   logic signed [ValueW-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.en) begin
         case (ctrl.kind)
            KIND_PUSH_FRONT: begin
               valid_in = left_valid;
               data_in  = left_data;
            end
            KIND_PUSH_BACK: begin
               // first free slot takes the word
               if (!valid_ff && left_valid) begin
                  valid_in = 1'b1;
                  data_in  = ctrl.value;
               end
            end
            KIND_POP_FRONT: begin
               valid_in = right_valid;
               data_in  = right_data;
            end
            KIND_POP_BACK: begin
               if (valid_ff && !right_valid) begin
                  valid_in = 1'b0;
               end
            end
            KIND_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid     = valid_ff;
   assign data      = data_ff;
   // only the last held cell offers its word
   assign tail_data = (valid_ff && !right_valid) ? data_ff : '0;

endmodule

FILE: sv/bdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the deque's response word, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker #(
   parameter int DEPTH = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bdq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bdq_pkg::rsp_type rsp_data
);
   import bdq_pkg::*;

   // an empty pop only happens with nothing held
   a_empty_pop : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_EMPTY)
         |-> (rsp_data.popped_value == '0 && rsp_data.entry_count == '0))
      else $error("empty pop with non-zero value or count");

   // a dropped push reports a full queue
   a_full_push : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL)
         |-> (rsp_data.popped_value == '0 && rsp_data.entry_count == CountW'(DEPTH)))
      else $error("full status with wrong count");

   // clear answers next cycle with an empty queue
   a_clear : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.kind == KIND_CLEAR)
         |=> (rsp_valid && rsp_data.entry_count == '0 && rsp_data.status == ST_DONE))
      else $error("clear did not empty the queue");

   // input only stalls behind a stalled response
   a_ready : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a waiting response");

   // stalled response holds
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind bounded_deque bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

FILE: tb/sv/bounded_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_tb
// Self-checking bench for the bounded deque. A short table of directed words
// comes first, then random runs of pushes, pops, clears and spare kinds.
// Every result word is checked against an in-bench ring model of the deque.
// ----------------------------------------------------------------------------
module bounded_deque_tb;
   import bdq_pkg::*;

   localparam int DEPTH    = 16;
   localparam int ITEMS    = 750;    // real operations wanted over the whole run
   localparam int HOLD_LEN = 300;    // long back-pressure stretch, in cycles
   localparam int SETTLE   = 20;     // quiet cycles after the last result
   localparam int LIMIT_NS = 5_000_000;

   // kinds the block takes as a no-op
   localparam logic [KindW-1:0] KIND_SPARE_LO  = 3'd5;
   localparam logic [KindW-1:0] KIND_SPARE_MID = 3'd6;
   localparam logic [KindW-1:0] KIND_SPARE_HI  = 3'd7;

   typedef struct packed {
      req_type w;
      bit      typed;    // expected word given in the row itself
      rsp_type rsp;
   } dir_row_type;

   // Directed rows. Typed rows are the ones obvious by eye; others use the
   // ring model. Pushing front from reset wraps the front index under zero.
   localparam int DIR_ROWS = 19;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{'{KIND_POP_FRONT,  32'h0000_0000}, 1'b1, '{32'h0000_0000, ST_EMPTY, 5'd0}},
      '{'{KIND_POP_BACK,   32'h1234_5678}, 1'b1, '{32'h0000_0000, ST_EMPTY, 5'd0}},
      '{'{KIND_PUSH_FRONT, 32'h7FFF_FFFF}, 1'b1, '{32'h0000_0000, ST_DONE,  5'd1}},
      '{'{KIND_PUSH_BACK,  32'h8000_0000}, 1'b1, '{32'h0000_0000, ST_DONE,  5'd2}},
      '{'{KIND_POP_FRONT,  32'hFFFF_FFFF}, 1'b1, '{32'h7FFF_FFFF, ST_DONE,  5'd1}},
      '{'{KIND_POP_BACK,   32'h0000_0000}, 1'b1, '{32'h8000_0000, ST_DONE,  5'd0}},
      '{'{KIND_PUSH_BACK,  32'hFFFF_FFFF}, 1'b0, '0},
      '{'{KIND_PUSH_FRONT, 32'h0000_0000}, 1'b0, '0},
      '{'{KIND_PUSH_FRONT, 32'h5555_5555}, 1'b0, '0},
      '{'{KIND_PUSH_BACK,  32'hAAAA_AAAA}, 1'b0, '0},
      '{'{KIND_SPARE_LO,   32'hDEAD_BEEF}, 1'b1, '{32'h0000_0000, ST_DONE,  5'd4}},
      '{'{KIND_SPARE_MID,  32'h7FFF_FFFF}, 1'b1, '{32'h0000_0000, ST_DONE,  5'd4}},
      '{'{KIND_SPARE_HI,   32'h8000_0000}, 1'b1, '{32'h0000_0000, ST_DONE,  5'd4}},
      '{'{KIND_POP_FRONT,  32'h0000_0000}, 1'b0, '0},
      '{'{KIND_POP_BACK,   32'h0000_0000}, 1'b0, '0},
      '{'{KIND_CLEAR,      32'hFFFF_FFFF}, 1'b1, '{32'h0000_0000, ST_DONE,  5'd0}},
      '{'{KIND_POP_FRONT,  32'h0000_0000}, 1'b1, '{32'h0000_0000, ST_EMPTY, 5'd0}},
      '{'{KIND_PUSH_BACK,  32'h0000_0001}, 1'b0, '0},
      '{'{KIND_POP_FRONT,  32'h0000_0000}, 1'b0, '0}
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   bounded_deque #(.DEPTH(DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ring model of the deque: front index, slot past the back, fill level
   logic [ValueW-1:0] ring_words [DEPTH];
   int unsigned       front_pos;
   int unsigned       back_pos;
   int unsigned       fill_level;

   rsp_type expected_rsps [$];

   int unsigned words_sent;
   int unsigned ops_sent;         // words of a real kind, spares not counted
   int unsigned results_checked;
   int unsigned full_drops;
   int unsigned empty_pops;
   int unsigned clears;
   int unsigned input_stalls;
   int unsigned errors;
   bit          long_hold_req;
   int          sender_calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("bounded_deque_tb failed");
      $finish;
   end

   // Applies one word to the ring model and returns the word it should give.
   function automatic rsp_type deque_apply(req_type w);
      rsp_type r;
      r = '0;
      r.status = ST_DONE;
      case (w.kind)
         KIND_PUSH_FRONT: begin
            if (fill_level >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               front_pos = (front_pos == 0) ? DEPTH - 1 : front_pos - 1;
               ring_words[front_pos] = w.push_value;
               fill_level++;
            end
         end
         KIND_PUSH_BACK: begin
            if (fill_level >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               ring_words[back_pos] = w.push_value;
               back_pos = (back_pos + 1 >= DEPTH) ? 0 : back_pos + 1;
               fill_level++;
            end
         end
         KIND_POP_FRONT: begin
            if (fill_level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.popped_value = ring_words[front_pos];
               front_pos = (front_pos + 1 >= DEPTH) ? 0 : front_pos + 1;
               fill_level--;
            end
         end
         KIND_POP_BACK: begin
            if (fill_level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               back_pos = (back_pos == 0) ? DEPTH - 1 : back_pos - 1;
               r.popped_value = ring_words[back_pos];
               fill_level--;
            end
         end
         KIND_CLEAR: begin
            front_pos  = 0;
            back_pos   = 0;
            fill_level = 0;
         end
         default: ;
      endcase
      r.entry_count = CountW'(fill_level);
      return r;
   endfunction

   // Push values lean on the extremes now and then.
   function automatic logic [ValueW-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Offers one word after a random gap, holds it until taken, then records
   // what should come back. Valid stays high across back-to-back words.
   task automatic send_word(input req_type w, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      if (sender_calm > 0) begin
         gap = 0;
         sender_calm--;
      end else begin
         if ($urandom_range(0, 15) == 0) sender_calm = $urandom_range(10, 40);
         gap = $urandom_range(0, 11);
      end
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      predicted = deque_apply(w);
      expected_rsps.push_back(typed ? typed_rsp : predicted);
      words_sent++;
      if (w.kind <= KIND_CLEAR) ops_sent++;
      if (predicted.status == ST_FULL) full_drops++;
      if (predicted.status == ST_EMPTY) empty_pops++;
      if (w.kind == KIND_CLEAR) clears++;
   endtask

   task automatic send_kind(input logic [KindW-1:0] kind);
      req_type w;
      w.kind       = kind;
      w.push_value = pick_value();
      send_word(w, 1'b0, '0);
   endtask

   // sender goes quiet until every outstanding result has come back
   task automatic drain_wait();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic push_run(input int n);
      repeat (n) send_kind($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK);
   endtask

   task automatic pop_run(input int n);
      repeat (n) send_kind($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK);
   endtask

   task automatic mixed_run(input int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            send_kind(KindW'($urandom_range(KIND_PUSH_FRONT, KIND_PUSH_BACK)));
         else if (pick < 90)
            send_kind(KindW'($urandom_range(KIND_POP_FRONT, KIND_POP_BACK)));
         else if (pick < 95)
            send_kind(KIND_CLEAR);
         else
            send_kind(KindW'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)));
      end
   endtask

   // Stimulus: directed table, then random runs shaped to hit full and empty.
   initial begin
      bit hold_done;
      bit pause_done;
      int shape;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      front_pos     = 0;
      back_pos      = 0;
      fill_level    = 0;
      long_hold_req = 1'b0;
      sender_calm   = 0;
      hold_done     = 1'b0;
      pause_done    = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_word(DIRECTED[i].w, DIRECTED[i].typed, DIRECTED[i].rsp);
      end
      drain_wait();

      // fill well past full from both ends, then drain past empty
      push_run(DEPTH + 3);
      pop_run(DEPTH + 3);

      while (ops_sent < ITEMS) begin
         if (!hold_done && ops_sent >= ITEMS / 3) begin
            // receiver sits on its ready while the sender keeps offering
            hold_done     = 1'b1;
            long_hold_req = 1'b1;
         end
         if (!pause_done && ops_sent >= 2 * ITEMS / 3) begin
            pause_done = 1'b1;
            drain_wait();
         end
         shape = $urandom_range(0, 9);
         if (shape <= 2)      push_run(DEPTH - fill_level + $urandom_range(1, 3));
         else if (shape <= 4) pop_run(fill_level + $urandom_range(1, 3));
         else if (shape <= 8) mixed_run($urandom_range(8, 30));
         else repeat ($urandom_range(1, 4))
            send_kind(KindW'($urandom_range(KIND_CLEAR, KIND_SPARE_HI)));
      end

      drain_wait();
      repeat (SETTLE) @(posedge clock);

      $display("run: %0d words (%0d real operations), %0d results checked",
               words_sent, ops_sent, results_checked);
      $display("run: %0d full drops, %0d empty pops, %0d clears, input stalled %0d cycles",
               full_drops, empty_pops, clears, input_stalls);
      if (errors == 0) begin
         $display("bounded_deque_tb passed");
      end else begin
         $display("bounded_deque_tb failed");
      end
      $finish;
   end

   // Receiver: random stall per word, calm stretches, and one long hold-off
   // counted here so the block backs up and drops req_ready.
   initial begin
      int stall;
      int calm;
      rsp_ready = 1'b0;
      calm      = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            repeat (HOLD_LEN) @(negedge clock) rsp_ready <= 1'b0;
         end
         if (calm > 0) begin
            stall = 0;
            calm--;
         end else begin
            if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
            stall = $urandom_range(0, 11);
         end
         repeat (stall) @(negedge clock) rsp_ready <= 1'b0;
         @(negedge clock) rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Result checker, sampling at the rising edge.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid && !req_ready) input_stalls++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: result word with none expected: %h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            results_checked++;
            if (rsp_data.popped_value !== want.popped_value) begin
               $display("%0t: popped_value expected %0d actual %0d",
                        $time, want.popped_value, rsp_data.popped_value);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.entry_count, rsp_data.entry_count);
               errors++;
            end
         end
      end
   end

endmodule

FILE: bounded_deque.f
sv/bdq_pkg.sv
sv/bdq_cell.sv
sv/bounded_deque.sv
sv/bdq_checker.sv
tb/sv/bounded_deque_tb.sv
